FILE: rtl/baro_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, constants and command codes of the compensation block.
// ----------------------------------------------------------------------------
package baro_pkg;

  localparam int unsigned Oversampling = 3;

  typedef struct packed {
    logic        op;
    logic [18:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        div_error;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_AC1 = 3'd0,
    REG_AC2 = 3'd1,
    REG_AC3 = 3'd2,
    REG_AC4 = 3'd3,
    REG_B1  = 3'd4,
    REG_B2  = 3'd5,
    REG_TC  = 3'd6,
    REG_NONE = 3'd7
  } reg_idx_e;

  // Datapath micro-operations issued by the controller
  typedef enum logic [5:0] {
    UOP_NOP,
    UOP_T_X1,     // x1 = asr((ut-c6)*c5,15), den = x1+md
    UOP_T_DIV,    // start signed divide mc*2048 / den
    UOP_T_END,    // b5 = x1+q, result
    UOP_P_B6,     // b6 = b5-4000
    UOP_P_SQ,     // sq = asr(b6*b6,12)
    UOP_P_M1,     // a = asr(b2*sq,11)
    UOP_P_M2,     // a = a + asr(ac2*b6,11)
    UOP_P_B3,     // b3
    UOP_P_M3,     // a = asr(ac3*b6,13)
    UOP_P_M4,     // a = asr(a + asr(b1*sq,16) + 2, 2)
    UOP_P_B4,     // b4 = ac4*(a+32768) >> 15
    UOP_P_B7,     // b7 = (up-b3)*(50000>>oss)
    UOP_P_DIV,    // start unsigned divide
    UOP_P_PQ,     // p from quotient
    UOP_P_PS,     // a = ps*ps
    UOP_P_M5,     // a = asr(a*3038,16)
    UOP_P_M6,     // a = a + asr(-7357*p,16)
    UOP_P_END     // p = p + asr(a+3791,4), result
  } uop_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    uop_e uop;
    logic load;
  } baro_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_zero;
    logic is_press;
  } baro_sts_t;

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
    asr32 = 32'($signed(v) >>> n);
  endfunction

endpackage

FILE: rtl/baro_div.sv
// ----------------------------------------------------------------------------
// Barometer compensation serial divider
// Unsigned 32 by 32 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module baro_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  // Shift in one dividend bit and try a subtract
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quo_q;

endmodule

FILE: rtl/baro_datapath.sv
// ----------------------------------------------------------------------------
// Barometer compensation datapath
// Working registers, one shared 32x32 multiplier and the serial divider.
// ----------------------------------------------------------------------------
module baro_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  baro_pkg::baro_cmd_t cmd_i,
  output baro_pkg::baro_sts_t sts_o,
  input  baro_pkg::in_item_t  item_i,
  input  logic [15:0]         ac1_i,
  input  logic [15:0]         ac2_i,
  input  logic [15:0]         ac3_i,
  input  logic [15:0]         ac4_i,
  input  logic [15:0]         b1_i,
  input  logic [15:0]         b2_i,
  input  logic [63:0]         tc_i,
  output baro_pkg::out_item_t res_o
);

  logic        op_q;
  logic [18:0] raw_q;
  logic [31:0] b5_q, b5_d;
  logic [31:0] x1_q, x1_d, b6_q, b6_d, sq_q, sq_d, acc_q, acc_d;
  logic [31:0] b3_q, b3_d, b4_q, b4_d, p_q, p_d, div_q_d;
  logic        neg_q, neg_d, zero_q, zero_d;
  logic [31:0] res_val_q, res_val_d;
  logic        res_err_q, res_err_d;
  logic [31:0] ma, mb, prod;
  logic        dstart;
  logic [31:0] dnd, dvs, quot;
  logic        dbusy;
  logic [31:0] c5, c6, mc, md, den, num, t, tq;

  assign c5 = {16'd0, tc_i[63:48]};
  assign c6 = {16'd0, tc_i[47:32]};
  assign mc = {{16{tc_i[31]}}, tc_i[31:16]};
  assign md = {{16{tc_i[15]}}, tc_i[15:0]};
  assign den = x1_q + md;
  assign num = mc << 11;

  baro_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dstart),
    .dividend_i(dnd),
    .divisor_i (dvs),
    .busy_o    (dbusy),
    .quot_o    (quot)
  );

  // Select multiplier operands for the current step
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.uop)
      baro_pkg::UOP_T_X1: begin ma = {13'd0, raw_q} - c6; mb = c5; end
      baro_pkg::UOP_P_SQ: begin ma = b6_q; mb = b6_q; end
      baro_pkg::UOP_P_M1: begin ma = {{16{b2_i[15]}}, b2_i}; mb = sq_q; end
      baro_pkg::UOP_P_M2: begin ma = {{16{ac2_i[15]}}, ac2_i}; mb = b6_q; end
      baro_pkg::UOP_P_M3: begin ma = {{16{ac3_i[15]}}, ac3_i}; mb = b6_q; end
      baro_pkg::UOP_P_M4: begin ma = {{16{b1_i[15]}}, b1_i}; mb = sq_q; end
      baro_pkg::UOP_P_B4: begin ma = {16'd0, ac4_i}; mb = acc_q + 32'd32768; end
      baro_pkg::UOP_P_B7: begin
        ma = {13'd0, raw_q} - b3_q;
        mb = 32'(50000 >> baro_pkg::Oversampling);
      end
      baro_pkg::UOP_P_PS: begin ma = baro_pkg::asr32(p_q, 8); mb = baro_pkg::asr32(p_q, 8); end
      baro_pkg::UOP_P_M5: begin ma = acc_q; mb = 32'd3038; end
      baro_pkg::UOP_P_M6: begin ma = 32'hFFFF_E343; mb = p_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = 32'(ma * mb);

  // Scaled offset term that B3 is taken from
  assign t  = (32'(32'($signed({{16{ac1_i[15]}}, ac1_i})) << 2) + acc_q) << baro_pkg::Oversampling;
  assign tq = t + 32'd2;

  // Step the working registers
  always_comb begin
    x1_d = x1_q; b6_d = b6_q; sq_d = sq_q; acc_d = acc_q; b3_d = b3_q;
    b4_d = b4_q; p_d = p_q; b5_d = b5_q; neg_d = neg_q; zero_d = zero_q;
    res_val_d = res_val_q; res_err_d = res_err_q;
    dstart = 1'b0; dnd = '0; dvs = '0; div_q_d = '0;
    unique case (cmd_i.uop)
      baro_pkg::UOP_T_X1: x1_d = baro_pkg::asr32(prod, 15);
      baro_pkg::UOP_T_DIV: begin
        zero_d = (den == '0);
        neg_d  = num[31] ^ den[31];
        dstart = (den != '0);
        dnd    = num[31] ? 32'(-num) : num;
        dvs    = den[31] ? 32'(-den) : den;
      end
      baro_pkg::UOP_T_END: begin
        div_q_d = neg_q ? 32'(-quot) : quot;
        res_err_d = zero_q;
        if (zero_q) begin
          res_val_d = '0;
        end else begin
          b5_d = x1_q + div_q_d;
          res_val_d = baro_pkg::asr32(b5_d + 32'd8, 4);
        end
      end
      baro_pkg::UOP_P_B6: b6_d = b5_q - 32'd4000;
      baro_pkg::UOP_P_SQ: sq_d = baro_pkg::asr32(prod, 12);
      baro_pkg::UOP_P_M1: acc_d = baro_pkg::asr32(prod, 11);
      baro_pkg::UOP_P_M2: acc_d = acc_q + baro_pkg::asr32(prod, 11);
      baro_pkg::UOP_P_B3: begin
        // Signed divide by four, truncating toward zero
        b3_d = tq[31] ? baro_pkg::asr32(tq + 32'd3, 2) : baro_pkg::asr32(tq, 2);
      end
      baro_pkg::UOP_P_M3: acc_d = baro_pkg::asr32(prod, 13);
      baro_pkg::UOP_P_M4: acc_d = baro_pkg::asr32(acc_q + baro_pkg::asr32(prod, 16) + 32'd2, 2);
      baro_pkg::UOP_P_B4: begin
        b4_d = prod >> 15;
        zero_d = ((prod >> 15) == '0);
      end
      baro_pkg::UOP_P_B7: acc_d = prod;
      baro_pkg::UOP_P_DIV: begin
        neg_d  = acc_q[31];
        dstart = !zero_q;
        dnd    = acc_q[31] ? acc_q : (acc_q << 1);
        dvs    = b4_q;
      end
      baro_pkg::UOP_P_PQ: p_d = neg_q ? (quot << 1) : quot;
      baro_pkg::UOP_P_PS: acc_d = prod;
      baro_pkg::UOP_P_M5: acc_d = baro_pkg::asr32(prod, 16);
      baro_pkg::UOP_P_M6: acc_d = acc_q + baro_pkg::asr32(prod, 16);
      baro_pkg::UOP_P_END: begin
        res_err_d = zero_q;
        res_val_d = zero_q ? '0 : p_q + baro_pkg::asr32(acc_q + 32'd3791, 4);
      end
      default: ;
    endcase
  end

  // Hold state; B5 survives between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_q <= '0;
    end else begin
      b5_q <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= item_i.op;
      raw_q <= item_i.raw_reading;
    end
    x1_q <= x1_d; b6_q <= b6_d; sq_q <= sq_d; acc_q <= acc_d; b3_q <= b3_d;
    b4_q <= b4_d; p_q <= p_d; neg_q <= neg_d; zero_q <= zero_d;
    res_val_q <= res_val_d; res_err_q <= res_err_d;
  end

  assign sts_o.div_busy = dbusy;
  assign sts_o.div_zero = zero_q;
  assign sts_o.is_press = op_q;
  assign res_o.kind      = op_q;
  assign res_o.value     = res_val_q;
  assign res_o.div_error = res_err_q;

endmodule

FILE: rtl/baro_ctrl.sv
// ----------------------------------------------------------------------------
// Barometer compensation controller
// Sequences datapath steps per item and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module baro_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output baro_pkg::baro_cmd_t cmd_o,
  input  baro_pkg::baro_sts_t sts_i
);

  baro_pkg::state_e state_q, state_d;
  baro_pkg::uop_e   uop_q, uop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= baro_pkg::ST_IDLE;
      uop_q   <= baro_pkg::UOP_NOP;
    end else begin
      state_q <= state_d;
      uop_q   <= uop_d;
    end
  end

  // Next state and step commands
  always_comb begin
    state_d = state_q;
    uop_d = uop_q;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.uop = baro_pkg::UOP_NOP;
    unique case (state_q)
      baro_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = baro_pkg::ST_RUN;
          uop_d = baro_pkg::UOP_NOP;
        end
      end
      baro_pkg::ST_RUN: begin
        cmd_o.uop = uop_q;
        unique case (uop_q)
          baro_pkg::UOP_NOP: begin
            uop_d = sts_i.is_press ? baro_pkg::UOP_P_B6 : baro_pkg::UOP_T_X1;
          end
          baro_pkg::UOP_T_X1:  uop_d = baro_pkg::UOP_T_DIV;
          baro_pkg::UOP_T_DIV: begin
            uop_d = baro_pkg::UOP_T_END;
            state_d = baro_pkg::ST_WAIT_DIV;
          end
          baro_pkg::UOP_T_END: state_d = baro_pkg::ST_OUT;
          baro_pkg::UOP_P_B6:  uop_d = baro_pkg::UOP_P_SQ;
          baro_pkg::UOP_P_SQ:  uop_d = baro_pkg::UOP_P_M1;
          baro_pkg::UOP_P_M1:  uop_d = baro_pkg::UOP_P_M2;
          baro_pkg::UOP_P_M2:  uop_d = baro_pkg::UOP_P_B3;
          baro_pkg::UOP_P_B3:  uop_d = baro_pkg::UOP_P_M3;
          baro_pkg::UOP_P_M3:  uop_d = baro_pkg::UOP_P_M4;
          baro_pkg::UOP_P_M4:  uop_d = baro_pkg::UOP_P_B4;
          baro_pkg::UOP_P_B4:  uop_d = baro_pkg::UOP_P_B7;
          baro_pkg::UOP_P_B7:  uop_d = baro_pkg::UOP_P_DIV;
          baro_pkg::UOP_P_DIV: begin
            if (sts_i.div_zero) begin
              uop_d = baro_pkg::UOP_P_END;
            end else begin
              uop_d = baro_pkg::UOP_P_PQ;
              state_d = baro_pkg::ST_WAIT_DIV;
            end
          end
          baro_pkg::UOP_P_PQ:  uop_d = baro_pkg::UOP_P_PS;
          baro_pkg::UOP_P_PS:  uop_d = baro_pkg::UOP_P_M5;
          baro_pkg::UOP_P_M5:  uop_d = baro_pkg::UOP_P_M6;
          baro_pkg::UOP_P_M6:  uop_d = baro_pkg::UOP_P_END;
          baro_pkg::UOP_P_END: state_d = baro_pkg::ST_OUT;
          default:             state_d = baro_pkg::ST_OUT;
        endcase
      end
      baro_pkg::ST_WAIT_DIV: begin
        // Hold until the divider drains
        if (!sts_i.div_busy) begin
          state_d = baro_pkg::ST_RUN;
        end
      end
      baro_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = baro_pkg::ST_IDLE;
        end
      end
      default: state_d = baro_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/barometer_compensation.sv
// ----------------------------------------------------------------------------
// Barometer compensation
// Integer temperature and pressure compensation with factory coefficients.
// ----------------------------------------------------------------------------
// One item at a time. The serial divider sets most of the time an item
// takes, plus output wait; the rest is one step of the shared multiplier
// per cycle. B5 from the last good temperature item feeds later pressure
// items (zero after reset).
// Write coefficients only while the block is idle.
module barometer_compensation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  baro_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output baro_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, b1_q, b2_q;
  logic [63:0] tc_q;
  baro_pkg::baro_cmd_t cmd;
  baro_pkg::baro_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Capture coefficient writes; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q <= '0; ac2_q <= '0; ac3_q <= '0; ac4_q <= '0;
      b1_q <= '0; b2_q <= '0; tc_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (baro_pkg::reg_idx_e'(cfg_index_i))
        baro_pkg::REG_AC1: ac1_q <= cfg_data_i[15:0];
        baro_pkg::REG_AC2: ac2_q <= cfg_data_i[15:0];
        baro_pkg::REG_AC3: ac3_q <= cfg_data_i[15:0];
        baro_pkg::REG_AC4: ac4_q <= cfg_data_i[15:0];
        baro_pkg::REG_B1:  b1_q  <= cfg_data_i[15:0];
        baro_pkg::REG_B2:  b2_q  <= cfg_data_i[15:0];
        baro_pkg::REG_TC:  tc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  baro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  baro_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts),
    .item_i(in_item_i),
    .ac1_i (ac1_q),
    .ac2_i (ac2_q),
    .ac3_i (ac3_q),
    .ac4_i (ac4_q),
    .b1_i  (b1_q),
    .b2_i  (b2_q),
    .tc_i  (tc_q),
    .res_o (out_item_o)
  );

endmodule

FILE: dv/baro_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation checker
// Watches the input, output and coefficient channels, predicts each
// compensated result and compares it field by field with the block output.
// ----------------------------------------------------------------------------
module baro_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  baro_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  baro_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, b1_q, b2_q;
  logic [63:0] tc_q;
  logic [31:0] b5_q;
  baro_pkg::out_item_t expected_q[$];

  function automatic logic [31:0] sra(logic [31:0] v, int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Compute the compensated result and update the kept B5
  function automatic baro_pkg::out_item_t compensate(baro_pkg::in_item_t it);
    baro_pkg::out_item_t r;
    logic [31:0] raw, c5, c6, mc, md, x1, x2, x3, den, b5, b6, sq, t, b3;
    logic [31:0] b4, b7, p, ps;
    raw = {13'd0, it.raw_reading};
    r.kind = it.op;
    r.value = '0;
    r.div_error = 1'b0;
    if (it.op == 1'b0) begin
      c5 = {16'd0, tc_q[63:48]};
      c6 = {16'd0, tc_q[47:32]};
      mc = sext(tc_q[31:16]);
      md = sext(tc_q[15:0]);
      x1 = sra((raw - c6) * c5, 15);
      den = x1 + md;
      if (den == 0) begin
        r.div_error = 1'b1;
      end else begin
        x2 = 32'($signed(mc * 32'd2048) / $signed(den));
        b5 = x1 + x2;
        b5_q = b5;
        r.value = sra(b5 + 32'd8, 4);
      end
    end else begin
      b6 = b5_q - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(sext(b2_q) * sq, 11);
      x2 = sra(sext(ac2_q) * b6, 11);
      x3 = x1 + x2;
      t = ((sext(ac1_q) * 32'd4) + x3) << baro_pkg::Oversampling;
      b3 = 32'($signed(t + 32'd2) / 32'sd4);
      x1 = sra(sext(ac3_q) * b6, 13);
      x2 = sra(sext(b1_q) * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = ({16'd0, ac4_q} * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) begin
        r.div_error = 1'b1;
      end else begin
        b7 = (raw - b3) * (32'd50000 >> baro_pkg::Oversampling);
        if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        ps = sra(p, 8);
        x1 = ps * ps;
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(32'hFFFF_E343 * p, 16);
        r.value = p + sra(x1 + x2 + 32'd3791, 4);
      end
    end
    return r;
  endfunction

  // Track coefficients, predict on input transfers, compare on output transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    baro_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      ac1_q <= '0; ac2_q <= '0; ac3_q <= '0; ac4_q <= '0;
      b1_q <= '0; b2_q <= '0; tc_q <= '0; b5_q = '0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (baro_pkg::reg_idx_e'(cfg_index_i))
          baro_pkg::REG_AC1: ac1_q <= cfg_data_i[15:0];
          baro_pkg::REG_AC2: ac2_q <= cfg_data_i[15:0];
          baro_pkg::REG_AC3: ac3_q <= cfg_data_i[15:0];
          baro_pkg::REG_AC4: ac4_q <= cfg_data_i[15:0];
          baro_pkg::REG_B1:  b1_q  <= cfg_data_i[15:0];
          baro_pkg::REG_B2:  b2_q  <= cfg_data_i[15:0];
          baro_pkg::REG_TC:  tc_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(compensate(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result %h", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.kind !== out_item_i.kind || exp_item.value !== out_item_i.value ||
              exp_item.div_error !== out_item_i.div_error) begin
            if (fail_count_o < 10)
              $display("ERROR: kind/value/err expected %0d/%0d/%0d actual %0d/%0d/%0d",
                       exp_item.kind, $signed(exp_item.value), exp_item.div_error,
                       out_item_i.kind, $signed(out_item_i.value), out_item_i.div_error);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Loads coefficient sets, drives directed and random temperature and
// pressure readings with random idling, and reports the checker verdict.
// ----------------------------------------------------------------------------
module testbench;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  baro_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  baro_pkg::out_item_t out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [63:0]         cfg_data_i = '0;
  int                  fail_count;
  int                  pending;
  bit                  quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  barometer_compensation dut (.*);

  baro_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the output in random bursts until the quiet tail
  always @(posedge clk_i) begin
    if (quiet || $urandom_range(0, 3) != 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Hold valid after the transfer; the caller drops it after the last write
  task automatic write_reg(baro_pkg::reg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_coeffs(logic [15:0] a1, a2, a3, a4, b1, b2, logic [63:0] tc);
    write_reg(baro_pkg::REG_AC1, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | {48'd0, a1});
    write_reg(baro_pkg::REG_AC2, {48'd0, a2});
    write_reg(baro_pkg::REG_AC3, {48'd0, a3});
    write_reg(baro_pkg::REG_AC4, {48'd0, a4});
    write_reg(baro_pkg::REG_B1, {48'd0, b1});
    write_reg(baro_pkg::REG_B2, {48'd0, b2});
    write_reg(baro_pkg::REG_TC, tc);
    write_reg(baro_pkg::REG_NONE, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  // Idle before the transfer only, so back to back items keep valid high
  task automatic send_reading(logic op, logic [18:0] raw);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{op: op, raw_reading: raw};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Let the block drain before touching coefficients
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_coeffs();
    load_coeffs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), {$urandom, $urandom});
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Pressure before any temperature, with reset coefficients: zero divisor
    send_reading(1'b1, 19'h12345);
    send_reading(1'b0, 19'd0);
    drain();
    // Typical factory coefficients
    load_coeffs(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd6190, 16'd4,
                {16'd32757, 16'd23153, -16'sd8711, 16'd2868});
    send_reading(1'b0, 19'd27898);
    send_reading(1'b1, 19'd23843 << 3);
    send_reading(1'b0, 19'd0);
    send_reading(1'b0, 19'h7FFFF);
    send_reading(1'b1, 19'd0);
    send_reading(1'b1, 19'h7FFFF);
    drain();
    // Extreme coefficients, and a zero temperature divisor (c5 = 0, md = 0)
    load_coeffs(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000,
                64'h0000_FFFF_8000_0000);
    send_reading(1'b0, 19'd1000);
    send_reading(1'b1, 19'd1000);
    send_reading(1'b1, 19'h7FFFF);
    drain();
    load_coeffs(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'h8000, 16'h7FFF,
                64'hFFFF_0000_7FFF_FFFF);
    send_reading(1'b0, 19'h7FFFF);
    send_reading(1'b1, 19'd5);
    send_reading(1'b0, 19'd0);
    drain();
    // Random phases: mostly realistic temperature/pressure pairs
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 2) random_coeffs();
      else load_coeffs(16'($urandom_range(0, 9000)), -16'($urandom_range(0, 400)),
                       -16'($urandom_range(10000, 16000)),
                       16'($urandom_range(30000, 36000)), 16'($urandom_range(5000, 7000)),
                       16'($urandom_range(0, 50)),
                       {16'($urandom_range(24000, 33000)), 16'($urandom_range(18000, 24000)),
                        -16'($urandom_range(8000, 12000)), 16'($urandom_range(2000, 3500))});
      if (ph == 11) quiet = 1'b1;
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 3) != 0)
          send_reading(n[0], n[0] ? 19'($urandom_range(120000, 360000))
                                  : 19'($urandom_range(20000, 34000)));
        else
          send_reading(1'($urandom), 19'($urandom));
      end
      drain();
    end
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: sim.f
rtl/baro_pkg.sv
rtl/baro_div.sv
rtl/baro_datapath.sv
rtl/baro_ctrl.sv
rtl/barometer_compensation.sv
dv/baro_checker.sv
dv/testbench.sv
